// File: rtl/bei_pkg.sv
// Shared types, constants and constant tables for the Bezier easing interpolator.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps
`default_nettype none

package bei_pkg;

  // Curve grid and solver limits
  localparam int TABLE_STEPS = 16;
  localparam int MAX_PASSES  = 32;

  // Fixed-point formats
  localparam int FRAC      = 24;             // internal Q2.24
  localparam int OUT_FRAC  = 16;             // Q1.16 at the ports
  localparam int Q_W       = 32;             // internal value width
  localparam int T_W       = 26;             // curve parameter, [-2.0, 2.0)
  localparam int IN_W      = 17;
  localparam int CTRL_W    = 7;
  localparam int CFG_IDX_W = 2;

  // Shared multiplier operand and product widths
  localparam int MA_W = 33;
  localparam int MB_W = 32;
  localparam int MP_W = MA_W + MB_W;

  // Derived widths
  localparam int GI_W     = $clog2(TABLE_STEPS + 1);
  localparam int IDX_W    = $clog2(TABLE_STEPS);
  localparam int PASS_W   = (MAX_PASSES > 1) ? $clog2(MAX_PASSES) : 1;
  localparam int SCALED_W = IN_W + GI_W;
  localparam int ERR_W    = Q_W + 1;
  localparam int TW_W     = Q_W + 2;
  localparam int YI_W     = MA_W + 1;

  typedef logic signed [Q_W-1:0]  qv_t;
  typedef logic signed [T_W-1:0]  tq_t;
  typedef logic        [IN_W-1:0] q116_t;
  typedef logic        [CTRL_W-1:0] ctrl_t;
  typedef logic signed [MA_W-1:0] ma_t;
  typedef logic signed [MB_W-1:0] mb_t;
  typedef logic signed [MP_W-1:0] mp_t;
  typedef logic signed [ERR_W-1:0] err_t;
  typedef logic signed [TW_W-1:0] tw_t;
  typedef logic signed [YI_W-1:0] yi_t;

  localparam qv_t   ONE_Q   = qv_t'(longint'(1) << FRAC);
  localparam qv_t   TOL_Q   = qv_t'(1678);
  localparam tq_t   T_MAX   = {1'b0, {(T_W-1){1'b1}}};
  localparam tq_t   T_MIN   = {1'b1, {(T_W-1){1'b0}}};
  localparam q116_t ONE_OUT = q116_t'(longint'(1) << OUT_FRAC);

  // Configuration register indexes and reset values
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_X1 = 2'd0,
    CFG_Y1 = 2'd1,
    CFG_X2 = 2'd2,
    CFG_Y2 = 2'd3
  } cfg_reg_t;

  localparam ctrl_t CTRL_X1_RST = ctrl_t'(20);
  localparam ctrl_t CTRL_Y1_RST = ctrl_t'(20);
  localparam ctrl_t CTRL_X2_RST = ctrl_t'(107);
  localparam ctrl_t CTRL_Y2_RST = ctrl_t'(107);

  // Scaled Bernstein coefficients and the identity flag
  typedef struct packed {
    qv_t  cx1;
    qv_t  cx2;
    qv_t  cy1;
    qv_t  cy2;
    logic ident;
  } bei_coef_t;

  // Multiply steps of one curve evaluation, in issue order
  typedef enum logic [2:0] {
    OP_TT  = 3'd0,   // t*t       -> t2
    OP_II  = 3'd1,   // inv*inv   -> inv2
    OP_I2T = 3'd2,   // inv2*t    -> tmp
    OP_MC1 = 3'd3,   // tmp*c1    -> acc
    OP_IT2 = 3'd4,   // t2*inv    -> tmp
    OP_MC2 = 3'd5,   // tmp*c2    -> acc +=
    OP_T2T = 3'd6    // t2*t      -> acc +=
  } bez_op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SETUP,
    ST_GRID,
    ST_MUL,
    ST_WB,
    ST_EVAL,
    ST_STORE,
    ST_IMUL,
    ST_IWB,
    ST_DONE
  } core_state_t;

  // Control byte scaled by 3/127 into Q2.24, rounded
  typedef qv_t scale_tab_t [2**CTRL_W];

  function automatic scale_tab_t build_scale_tab();
    scale_tab_t tab;
    longint     v;
    for (int i = 0; i < 2**CTRL_W; i++) begin
      v = (longint'(i) * 3 * (longint'(1) << FRAC) + 63) / 127;
      tab[i] = qv_t'(v);
    end
    return tab;
  endfunction

  localparam scale_tab_t SCALE_TAB = build_scale_tab();

  // Grid abscissas i/TABLE_STEPS in Q2.24, rounded
  typedef qv_t xg_tab_t [TABLE_STEPS];

  function automatic xg_tab_t build_xg_tab();
    xg_tab_t tab;
    longint  v;
    for (int i = 0; i < TABLE_STEPS; i++) begin
      v = (longint'(i) * (longint'(1) << FRAC) + TABLE_STEPS / 2) / TABLE_STEPS;
      tab[i] = qv_t'(v);
    end
    return tab;
  endfunction

  localparam xg_tab_t XG_TAB = build_xg_tab();

endpackage

`default_nettype wire

// File: rtl/bei_in_if.sv
// Input channel of the Bezier easing interpolator: valid/ready plus progress.
// Depends on bei_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface bei_in_if import bei_pkg::*; ();
  logic  valid;
  logic  ready;
  q116_t progress;

  modport source (output valid, output progress, input ready);
  modport sink   (input valid, input progress, output ready);
endinterface

`default_nettype wire

// File: rtl/bei_out_if.sv
// Result channel of the Bezier easing interpolator: valid/ready plus eased.
// Depends on bei_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface bei_out_if import bei_pkg::*; ();
  logic  valid;
  logic  ready;
  q116_t eased;

  modport source (output valid, output eased, input ready);
  modport sink   (input valid, input eased, output ready);
endinterface

`default_nettype wire

// File: rtl/bezier_easing_interpolator.sv
// Top level of the Bezier easing interpolator: channels, control registers,
// output register. Depends on bei_pkg, bei_in_if, bei_out_if, bei_cfg, bei_core.
//
// Usage:
//   in_if  : one transaction carries progress x in Q1.16 (values above 1.0
//            saturate). in_if.ready is high while the solver is idle.
//   out_if : one transaction per input carries eased y in Q1.16.
//   cfg_*  : write ctrl_x1, ctrl_y1, ctrl_x2, ctrl_y2 (indexes 0..3) while idle.
// Sequence: an identity curve or x = 1.0 goes from setup straight to the
//   output hand-off. Otherwise each of the two grid points around x is a
//   fixed end (0 or 1) or is solved by n x(t) evaluations, where n is
//   1..MAX_PASSES and ends when the error test passes, and one y(t) evaluation;
//   one evaluation is seven multiply steps (each issued, then written back)
//   on the single shared multiplier plus one check step. Setup comes first;
//   interpolation between the two grid values and the hand-off come last.
// Throughput: one transaction at a time; the next input is taken as soon as
//   the result has moved to the output register, even while it waits there.
// Reset (rst_n low, synchronous): control points return to 20/20/107/107,
//   the solver goes idle and the output register empties.
// Stall: a held output keeps its value; a finished result waits in the
//   solver until the output register frees, and no input is taken meanwhile.
`timescale 1ns / 1ps
`default_nettype none

module bezier_easing_interpolator import bei_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  bei_in_if.sink                    in_if,
  bei_out_if.source                 out_if,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CTRL_W-1:0]    cfg_wdata
);

  bei_coef_t coef;
  logic      core_idle;
  logic      core_start;
  logic      res_valid;
  logic      res_ready;
  q116_t     res_eased;
  logic      out_valid_r;
  q116_t     out_eased_r;

  bei_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .coef      (coef)
  );

  // Accept a transaction whenever the solver is idle
  assign in_if.ready = core_idle;
  assign core_start  = in_if.valid && core_idle;

  bei_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .coef      (coef),
    .start     (core_start),
    .progress  (in_if.progress),
    .idle      (core_idle),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_eased (res_eased)
  );

  // Output register: load when empty or being drained
  assign res_ready = !out_valid_r || out_if.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_eased_r <= res_eased;
    end
  end

  assign out_if.valid = out_valid_r;
  assign out_if.eased = out_eased_r;

endmodule

`default_nettype wire

// File: rtl/bei_cfg.sv
// Control point registers and their scaled Bernstein coefficients.
// Depends on bei_pkg (register indexes, reset values, scale table).
`timescale 1ns / 1ps
`default_nettype none

module bei_cfg import bei_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CTRL_W-1:0]    cfg_wdata,
  output bei_coef_t                 coef
);

  ctrl_t x1_r, y1_r, x2_r, y2_r;

  // Write the addressed control byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x1_r <= CTRL_X1_RST;
      y1_r <= CTRL_Y1_RST;
      x2_r <= CTRL_X2_RST;
      y2_r <= CTRL_Y2_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_X1:  x1_r <= cfg_wdata;
        CFG_Y1:  y1_r <= cfg_wdata;
        CFG_X2:  x2_r <= cfg_wdata;
        CFG_Y2:  y2_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Scale to coefficients; both points on the diagonal means identity curve
  always_comb begin
    coef.cx1   = SCALE_TAB[x1_r];
    coef.cy1   = SCALE_TAB[y1_r];
    coef.cx2   = SCALE_TAB[x2_r];
    coef.cy2   = SCALE_TAB[y2_r];
    coef.ident = (x1_r == y1_r) && (x2_r == y2_r);
  end

endmodule

`default_nettype wire

// File: rtl/bei_mul.sv
// Shared signed multiplier with a registered product.
// Depends on bei_pkg (operand and product widths).
`timescale 1ns / 1ps
`default_nettype none

module bei_mul import bei_pkg::*; (
  input  wire logic clk,
  input  wire logic en,
  input  wire ma_t  a,
  input  wire mb_t  b,
  output mp_t       prod
);

  mp_t prod_r;

  // Capture the product when a step is issued
  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= mp_t'(a) * mp_t'(b);
    end
  end

  assign prod = prod_r;

endmodule

`default_nettype wire

// File: rtl/bei_core.sv
// Sequencer and datapath: grid-point curve solves and the final interpolation,
// all multiplications on one shared bei_mul. Depends on bei_pkg and bei_mul.
`timescale 1ns / 1ps
`default_nettype none

module bei_core import bei_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire bei_coef_t coef,
  input  wire logic      start,
  input  wire q116_t     progress,
  output logic           idle,
  output logic           res_valid,
  input  wire logic      res_ready,
  output q116_t          res_eased
);

  core_state_t state_r, state_nxt;
  bez_op_t     op_r, op_nxt;
  logic [PASS_W-1:0] pass_r, pass_nxt;
  logic [GI_W-1:0]   gi_r, gi_nxt;
  logic [OUT_FRAC-1:0] frac_r, frac_nxt;
  logic  sel_r, sel_nxt;
  logic  ysel_r, ysel_nxt;
  q116_t x_r, x_nxt;
  q116_t res_r, res_nxt;
  tq_t   t_r, t_nxt;
  qv_t   t2_r, t2_nxt;
  qv_t   inv2_r, inv2_nxt;
  qv_t   tmp_r, tmp_nxt;
  qv_t   acc_r, acc_nxt;
  qv_t   y0_r, y0_nxt;
  qv_t   yg_r, yg_nxt;

  q116_t                 x_sat;
  logic [SCALED_W-1:0]   scaled;
  qv_t   inv, xg, c1, c2, q_res;
  mp_t   prod, prod_rnd, iprod_rnd;
  ma_t   mul_a;
  mb_t   mul_b;
  logic  mul_en;
  err_t  err, half;
  tw_t   t_upd;
  tq_t   t_sat;
  logic  err_small;
  yi_t   y_full, r_full;
  q116_t r_clamp;

  bei_mul u_mul (
    .clk  (clk),
    .en   (mul_en),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  // Saturate the input and locate its grid cell
  always_comb begin
    x_sat  = (progress > ONE_OUT) ? ONE_OUT : progress;
    scaled = SCALED_W'(x_sat) * SCALED_W'(TABLE_STEPS);
  end

  // Curve terms, coefficient select and rounding of the product
  always_comb begin
    inv       = ONE_Q - qv_t'(t_r);
    xg        = XG_TAB[gi_r[IDX_W-1:0]];
    c1        = ysel_r ? coef.cy1 : coef.cx1;
    c2        = ysel_r ? coef.cy2 : coef.cx2;
    prod_rnd  = prod + (mp_t'(1) <<< (FRAC - 1));
    q_res     = qv_t'(prod_rnd >>> FRAC);
    iprod_rnd = prod + (mp_t'(1) <<< (OUT_FRAC - 1));
  end

  // Damped update t -= err/2, saturated to [-2.0, 2.0)
  always_comb begin
    err       = err_t'(acc_r) - err_t'(xg);
    err_small = (err > -err_t'(TOL_Q)) && (err < err_t'(TOL_Q));
    half      = (err + err_t'(1)) >>> 1;
    t_upd     = tw_t'(t_r) - tw_t'(half);
    if (t_upd > tw_t'(T_MAX)) begin
      t_sat = T_MAX;
    end else if (t_upd < tw_t'(T_MIN)) begin
      t_sat = T_MIN;
    end else begin
      t_sat = tq_t'(t_upd);
    end
  end

  // Interpolate between the grid values and round to Q1.16
  always_comb begin
    y_full = yi_t'(y0_r) + yi_t'(iprod_rnd >>> OUT_FRAC);
    r_full = (y_full + yi_t'(1 <<< (FRAC - OUT_FRAC - 1))) >>> (FRAC - OUT_FRAC);
    if (r_full < yi_t'(0)) begin
      r_clamp = '0;
    end else if (r_full > yi_t'(ONE_OUT)) begin
      r_clamp = ONE_OUT;
    end else begin
      r_clamp = q116_t'(r_full);
    end
  end

  // Operand select for the shared multiplier
  always_comb begin
    mul_en = (state_r == ST_MUL) || (state_r == ST_IMUL);
    mul_a  = '0;
    mul_b  = '0;
    if (state_r == ST_IMUL) begin
      mul_a = ma_t'(yg_r) - ma_t'(y0_r);
      mul_b = $signed({{(MB_W-OUT_FRAC){1'b0}}, frac_r});
    end else begin
      case (op_r)
        OP_TT:   begin mul_a = ma_t'(t_r);    mul_b = mb_t'(t_r); end
        OP_II:   begin mul_a = ma_t'(inv);    mul_b = mb_t'(inv); end
        OP_I2T:  begin mul_a = ma_t'(inv2_r); mul_b = mb_t'(t_r); end
        OP_MC1:  begin mul_a = ma_t'(tmp_r);  mul_b = mb_t'(c1);  end
        OP_IT2:  begin mul_a = ma_t'(t2_r);   mul_b = mb_t'(inv); end
        OP_MC2:  begin mul_a = ma_t'(tmp_r);  mul_b = mb_t'(c2);  end
        OP_T2T:  begin mul_a = ma_t'(t2_r);   mul_b = mb_t'(t_r); end
        default: begin mul_a = '0;            mul_b = '0;         end
      endcase
    end
  end

  // State and datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      op_r    <= OP_TT;
      pass_r  <= '0;
      sel_r   <= 1'b0;
      ysel_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
      pass_r  <= pass_nxt;
      sel_r   <= sel_nxt;
      ysel_r  <= ysel_nxt;
    end
  end

  always_ff @(posedge clk) begin
    gi_r   <= gi_nxt;
    frac_r <= frac_nxt;
    x_r    <= x_nxt;
    res_r  <= res_nxt;
    t_r    <= t_nxt;
    t2_r   <= t2_nxt;
    inv2_r <= inv2_nxt;
    tmp_r  <= tmp_nxt;
    acc_r  <= acc_nxt;
    y0_r   <= y0_nxt;
    yg_r   <= yg_nxt;
  end

  // Sequencer: next state and register updates
  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    pass_nxt  = pass_r;
    sel_nxt   = sel_r;
    ysel_nxt  = ysel_r;
    gi_nxt    = gi_r;
    frac_nxt  = frac_r;
    x_nxt     = x_r;
    res_nxt   = res_r;
    t_nxt     = t_r;
    t2_nxt    = t2_r;
    inv2_nxt  = inv2_r;
    tmp_nxt   = tmp_r;
    acc_nxt   = acc_r;
    y0_nxt    = y0_r;
    yg_nxt    = yg_r;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          x_nxt     = x_sat;
          gi_nxt    = scaled[OUT_FRAC +: GI_W];
          frac_nxt  = scaled[OUT_FRAC-1:0];
          state_nxt = ST_SETUP;
        end
      end

      ST_SETUP: begin
        if (coef.ident) begin
          res_nxt   = x_r;
          state_nxt = ST_DONE;
        end else if (gi_r >= GI_W'(TABLE_STEPS)) begin
          res_nxt   = ONE_OUT;
          state_nxt = ST_DONE;
        end else begin
          sel_nxt   = 1'b0;
          state_nxt = ST_GRID;
        end
      end

      // Fixed ends of the grid, or start a solve at t = xg
      ST_GRID: begin
        if (gi_r == '0) begin
          yg_nxt    = '0;
          state_nxt = ST_STORE;
        end else if (gi_r >= GI_W'(TABLE_STEPS)) begin
          yg_nxt    = ONE_Q;
          state_nxt = ST_STORE;
        end else begin
          t_nxt     = tq_t'(xg);
          pass_nxt  = '0;
          ysel_nxt  = 1'b0;
          op_nxt    = OP_TT;
          state_nxt = ST_MUL;
        end
      end

      ST_MUL: begin
        state_nxt = ST_WB;
      end

      // Retire one multiply step
      ST_WB: begin
        case (op_r)
          OP_TT:   t2_nxt   = q_res;
          OP_II:   inv2_nxt = q_res;
          OP_I2T:  tmp_nxt  = q_res;
          OP_MC1:  acc_nxt  = q_res;
          OP_IT2:  tmp_nxt  = q_res;
          OP_MC2:  acc_nxt  = acc_r + q_res;
          OP_T2T:  acc_nxt  = acc_r + q_res;
          default: ;
        endcase
        if (op_r == OP_T2T) begin
          state_nxt = ST_EVAL;
        end else begin
          op_nxt    = bez_op_t'(op_r + 3'd1);
          state_nxt = ST_MUL;
        end
      end

      // Check the x error, update t, or take the finished y value
      ST_EVAL: begin
        if (ysel_r) begin
          yg_nxt    = acc_r;
          state_nxt = ST_STORE;
        end else begin
          op_nxt    = OP_TT;
          state_nxt = ST_MUL;
          if (err_small) begin
            ysel_nxt = 1'b1;
          end else begin
            t_nxt = t_sat;
            if (pass_r == PASS_W'(MAX_PASSES - 1)) begin
              ysel_nxt = 1'b1;
            end else begin
              pass_nxt = pass_r + PASS_W'(1);
            end
          end
        end
      end

      // Hold the left grid value and advance to the right one, or start the interpolation
      ST_STORE: begin
        if (!sel_r) begin
          y0_nxt    = yg_r;
          gi_nxt    = gi_r + GI_W'(1);
          sel_nxt   = 1'b1;
          state_nxt = ST_GRID;
        end else begin
          state_nxt = ST_IMUL;
        end
      end

      ST_IMUL: begin
        state_nxt = ST_IWB;
      end

      ST_IWB: begin
        res_nxt   = r_clamp;
        state_nxt = ST_DONE;
      end

      ST_DONE: begin
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign idle      = (state_r == ST_IDLE);
  assign res_valid = (state_r == ST_DONE);
  assign res_eased = res_r;

`ifndef SYNTHESIS
  a_start_setup: assert property (@(posedge clk) disable iff (!rst_n)
    start && idle |=> state_r == ST_SETUP)
    else $error("accepted transaction did not enter setup");

  a_step_chain: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WB) && (op_r != OP_T2T) |=> (state_r == ST_MUL) && (op_r == $past(op_r) + 3'd1))
    else $error("multiply step sequence broken");

  a_pass_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EVAL) && !ysel_r |-> pass_r <= PASS_W'(MAX_PASSES - 1))
    else $error("solver pass count out of range");

  a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && !res_ready |=> res_valid && $stable(res_eased))
    else $error("result dropped or changed while stalled");

  a_res_range: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> res_eased <= ONE_OUT)
    else $error("result above one");
`endif

endmodule

`default_nettype wire

// File: tb/bezier_easing_interpolator_test.sv
// Self-checking testbench for the Bezier easing interpolator: predicts each eased value
// from the control points and compares it with the result channel under random idling.
// Depends on bei_pkg, bei_in_if, bei_out_if and bezier_easing_interpolator.
`timescale 1ns / 1ps

module bezier_easing_interpolator_test;
  import bei_pkg::*;

  // Fixed-point constants of the curve solver (Q2.24 in 64-bit words)
  localparam longint FX_ONE  = longint'(1) << FRAC;
  localparam longint FX_TOL  = 1678;
  localparam longint FX_T_HI = (longint'(2) << FRAC) - 1;
  localparam longint FX_T_LO = -(longint'(2) << FRAC);
  localparam longint OUT_ONE = longint'(1) << OUT_FRAC;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CTRL_W-1:0]    cfg_wdata;

  bei_in_if  in_ch ();
  bei_out_if out_ch ();

  bezier_easing_interpolator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_ch),
    .out_if    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Control point copy, pending progress values and expected eased values
  ctrl_t       ctrl_shadow [4];
  q116_t       progress_backlog [$];
  q116_t       eased_due [$];
  q116_t       eased_want;
  int unsigned in_flight    = 0;
  int unsigned mismatches   = 0;
  int unsigned in_idle_pct  = 27;
  int unsigned out_idle_pct = 69;
  logic        in_fire      = 1'b0;

  always #6 clk = ~clk;

  // Scaled Bernstein coefficient of one control byte, 3*p/127 rounded
  function automatic longint ctrl_coef(ctrl_t p);
    return (longint'(p) * 3 * FX_ONE + 63) / 127;
  endfunction

  // Q2.24 product, rounded to nearest with ties up
  function automatic longint fx_mul(longint a, longint b);
    return (a * b + (longint'(1) << (FRAC - 1))) >>> FRAC;
  endfunction

  // One coordinate of the curve at parameter t
  function automatic longint curve_at(longint t, longint c1, longint c2);
    longint inv, inv2, t2;
    inv  = FX_ONE - t;
    inv2 = fx_mul(inv, inv);
    t2   = fx_mul(t, t);
    return fx_mul(fx_mul(inv2, t), c1) + fx_mul(fx_mul(inv, t2), c2) + fx_mul(t2, t);
  endfunction

  // Curve ordinate at grid abscissa idx/TABLE_STEPS
  function automatic longint grid_ordinate(int unsigned idx);
    longint xg, t, err, cx1, cx2, cy1, cy2;
    if (idx == 0) return 0;
    if (idx >= TABLE_STEPS) return FX_ONE;
    cx1 = ctrl_coef(ctrl_shadow[CFG_X1]);
    cx2 = ctrl_coef(ctrl_shadow[CFG_X2]);
    cy1 = ctrl_coef(ctrl_shadow[CFG_Y1]);
    cy2 = ctrl_coef(ctrl_shadow[CFG_Y2]);
    xg  = (longint'(idx) * FX_ONE + TABLE_STEPS / 2) / TABLE_STEPS;
    t   = xg;
    // damped search for x(t) = xg, clamp t to [-2, 2)
    for (int pass = 0; pass < MAX_PASSES; pass++) begin
      err = curve_at(t, cx1, cx2) - xg;
      if (err > -FX_TOL && err < FX_TOL) break;
      t = t - ((err + 1) >>> 1);
      if (t > FX_T_HI) t = FX_T_HI;
      if (t < FX_T_LO) t = FX_T_LO;
    end
    return curve_at(t, cy1, cy2);
  endfunction

  // Eased value for one progress value under the current control points
  function automatic q116_t eased_of(q116_t progress);
    longint      x, scaled, frac, y0, y1, y, r;
    int unsigned cell_idx;
    x = longint'(progress);
    if (x > OUT_ONE) x = OUT_ONE;
    if (ctrl_shadow[CFG_X1] == ctrl_shadow[CFG_Y1] &&
        ctrl_shadow[CFG_X2] == ctrl_shadow[CFG_Y2]) return q116_t'(x);
    scaled   = x * TABLE_STEPS;
    cell_idx = int'(scaled >> OUT_FRAC);
    frac     = scaled & (OUT_ONE - 1);
    if (cell_idx >= TABLE_STEPS) return q116_t'(OUT_ONE);
    y0 = grid_ordinate(cell_idx);
    y1 = grid_ordinate(cell_idx + 1);
    y  = y0 + (((y1 - y0) * frac + (longint'(1) << (OUT_FRAC - 1))) >>> OUT_FRAC);
    r  = (y + (longint'(1) << (FRAC - OUT_FRAC - 1))) >>> (FRAC - OUT_FRAC);
    if (r < 0) r = 0;
    if (r > OUT_ONE) r = OUT_ONE;
    return q116_t'(r);
  endfunction

  function automatic ctrl_t random_ctrl();
    case ($urandom_range(4))
      0:       return ctrl_t'(0);
      1:       return ctrl_t'(127);
      default: return ctrl_t'($urandom_range(127));
    endcase
  endfunction

  // Mostly in range, some at the ends, above one, or near a grid point
  function automatic q116_t random_progress();
    case ($urandom_range(9))
      0:       return $urandom_range(1) ? q116_t'(0) : q116_t'(OUT_ONE);
      1:       return q116_t'($urandom_range(131071, 65537));
      2:       return q116_t'($urandom_range(15) * 4096 + $urandom_range(8) - 4);
      default: return q116_t'($urandom_range(65536));
    endcase
  endfunction

  task automatic queue_progress(q116_t v);
    progress_backlog.push_back(v);
    in_flight++;
  endtask

  // Hold until every queued transaction has its result
  task automatic wait_idle();
    while (in_flight != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_ctrl(cfg_reg_t idx, ctrl_t val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    ctrl_shadow[idx] = val;
  endtask

  task automatic apply_curve(ctrl_t x1, ctrl_t y1, ctrl_t x2, ctrl_t y2);
    wait_idle();
    write_ctrl(CFG_X1, x1);
    write_ctrl(CFG_Y1, y1);
    write_ctrl(CFG_X2, x2);
    write_ctrl(CFG_Y2, y2);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Driver: present the next progress value, hold it until taken
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_fire) begin
      if (progress_backlog.size() != 0 && $urandom_range(99) >= in_idle_pct) begin
        in_ch.valid    <= 1'b1;
        in_ch.progress <= progress_backlog.pop_front();
      end else begin
        in_ch.valid    <= 1'b0;
        in_ch.progress <= q116_t'($urandom);
      end
    end
  end

  // Stall the result channel at random
  always @(negedge clk) begin
    out_ch.ready <= rst_n && ($urandom_range(99) >= out_idle_pct);
  end

  // Monitor: check each result transaction, predict each input transaction
  always @(posedge clk) begin
    in_fire <= rst_n && in_ch.valid && in_ch.ready;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (eased_due.size() == 0) begin
          $error("eased: expected nothing, got %0d", out_ch.eased);
          mismatches++;
        end else begin
          eased_want = eased_due.pop_front();
          if (out_ch.eased !== eased_want) begin
            $error("eased: expected %0d, got %0d", eased_want, out_ch.eased);
            mismatches++;
          end
          in_flight--;
        end
      end
      if (in_ch.valid && in_ch.ready) eased_due.push_back(eased_of(in_ch.progress));
    end
  end

  // Stimulus: directed curves and values, then random curves in three idling phases
  initial begin
    ctrl_t x1, y1, x2, y2;
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = CFG_X1;
    cfg_wdata      = '0;
    in_ch.valid    = 1'b0;
    in_ch.progress = '0;
    out_ch.ready   = 1'b0;
    ctrl_shadow[CFG_X1] = CTRL_X1_RST;
    ctrl_shadow[CFG_Y1] = CTRL_Y1_RST;
    ctrl_shadow[CFG_X2] = CTRL_X2_RST;
    ctrl_shadow[CFG_Y2] = CTRL_Y2_RST;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset curve is the identity
    queue_progress(q116_t'(0));
    queue_progress(q116_t'(65535));
    queue_progress(q116_t'(65536));
    queue_progress(q116_t'(131071));

    // extreme control points, both orientations
    apply_curve(ctrl_t'(0), ctrl_t'(127), ctrl_t'(127), ctrl_t'(0));
    queue_progress(q116_t'(0));
    queue_progress(q116_t'(1));
    queue_progress(q116_t'(4095));
    queue_progress(q116_t'(4096));
    queue_progress(q116_t'(32768));
    queue_progress(q116_t'(65535));
    queue_progress(q116_t'(65536));
    queue_progress(q116_t'(65537));
    queue_progress(q116_t'(131071));

    apply_curve(ctrl_t'(127), ctrl_t'(0), ctrl_t'(0), ctrl_t'(127));
    queue_progress(q116_t'(1));
    queue_progress(q116_t'(30000));
    queue_progress(q116_t'(61440));
    queue_progress(q116_t'(65535));
    queue_progress(q116_t'(65536));
    queue_progress(q116_t'(17'h1ABCD));

    // identity again, at the extremes
    apply_curve(ctrl_t'(0), ctrl_t'(0), ctrl_t'(127), ctrl_t'(127));
    queue_progress(q116_t'(12345));
    queue_progress(q116_t'(70000));

    // random curves; idling sender/receiver swap, then no idling at all
    for (int grp = 0; grp < 3; grp++) begin
      wait_idle();
      in_idle_pct  = (grp == 0) ? 27 : (grp == 1) ? 69 : 0;
      out_idle_pct = (grp == 0) ? 69 : (grp == 1) ? 27 : 0;
      for (int sub = 0; sub < 4; sub++) begin
        x1 = random_ctrl();
        y1 = random_ctrl();
        x2 = random_ctrl();
        y2 = random_ctrl();
        if ($urandom_range(5) == 0) begin
          y1 = x1;
          y2 = x2;
        end
        apply_curve(x1, y1, x2, y2);
        for (int n = 0; n < 50; n++) queue_progress(random_progress());
      end
    end

    wait_idle();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && eased_due.size() == 0) begin
      $display("PASS bezier_easing_interpolator");
    end else begin
      $display("FAIL bezier_easing_interpolator");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #40_000_000;
    $display("FAIL bezier_easing_interpolator");
    $finish;
  end

endmodule

// File: filelist.f
rtl/bei_pkg.sv
rtl/bei_in_if.sv
rtl/bei_out_if.sv
rtl/bei_cfg.sv
rtl/bei_mul.sv
rtl/bei_core.sv
rtl/bezier_easing_interpolator.sv
tb/bezier_easing_interpolator_test.sv
